// ----- hw/rtl/button_feedback_led_pattern_assert.svh -----
// Assertion macros for the button feedback LED pattern block.
`ifndef BUTTON_FEEDBACK_LED_PATTERN_ASSERT_SVH
`define BUTTON_FEEDBACK_LED_PATTERN_ASSERT_SVH

// Plain condition, sampled on every clock edge outside reset.
`define BFLP_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Condition that must hold whenever the antecedent holds.
`define BFLP_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bflp_pkg.sv -----
// Types and constants for the button feedback LED pattern block.
package bflp_pkg;

  typedef enum logic [2:0] {
    PAT_OFF    = 3'd0,
    PAT_SINGLE = 3'd1,
    PAT_DOUBLE = 3'd2,
    PAT_SLOW   = 3'd3,
    PAT_FAST   = 3'd4
  } pat_t;

  localparam logic [1:0] ACT_SINGLE = 2'd1;
  localparam logic [1:0] ACT_DOUBLE = 2'd2;

  localparam logic [3:0] BS_IDLE           = 4'd0;
  localparam logic [3:0] BS_PRESS_DEB      = 4'd1;
  localparam logic [3:0] BS_PRESSED        = 4'd2;
  localparam logic [3:0] BS_WAIT_SECOND    = 4'd3;
  localparam logic [3:0] BS_SECOND_DEB     = 4'd4;
  localparam logic [3:0] BS_SECOND_PRESSED = 4'd5;
  localparam logic [3:0] BS_RELEASE_DEB    = 4'd6;
  localparam logic [3:0] BS_LONG3S         = 4'd7;
  localparam logic [3:0] BS_LONG10S        = 4'd8;

  localparam logic [9:0] FLASH_MS      = 10'd100;
  localparam logic [9:0] DOUBLE_MS     = 10'd300;
  localparam logic [9:0] DOUBLE_GAP_MS = 10'd200;
  localparam logic [9:0] SLOW_HALF_MS  = 10'd500;
  localparam logic [9:0] SLOW_PERIOD   = 10'd1000;
  localparam logic [7:0] FAST_HALF_MS  = 8'd100;
  localparam logic [7:0] FAST_PERIOD   = 8'd200;

  // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for 32-bit x
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;

  localparam logic [8:0] ELAPSED_SAT = 9'd511;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  button_state;
    logic [31:0] delta_ms;
  } ev_word_t;

  typedef struct packed {
    logic       led_on;
    logic [2:0] pattern_now;
  } led_word_t;

endpackage

// ----- hw/rtl/button_feedback_led_pattern.sv -----
// Button feedback LED pattern generator: pipelined phase reduction and pattern state.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+--------------------------------------
//  event   | ev_valid  | ev_stall  | ev_word  (action, button_state, ms)
//  led     | led_valid | led_stall | led_word (led_on, pattern_now)
//
// One word in and one word out per cycle while led_stall is low; an accepted event word
// passes the input, quotient, remainder and result registers in turn to become its result word.
// The reciprocal multiply and the mod-1000 stage lie ahead of the pattern state
// update, which closes on itself.
// Synchronous reset clears valids, pattern and phase.
// Each stage holds while the one after it is full and stalled; bubbles close up.
module button_feedback_led_pattern (
  input  logic                clk,
  input  logic                rst,
  input  logic                ev_valid,
  output logic                ev_stall,
  input  bflp_pkg::ev_word_t  ev_word,
  output logic                led_valid,
  input  logic                led_stall,
  output bflp_pkg::led_word_t led_word
);

  // stage 1: input register
  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [3:0]  s1_bstate;
  logic [31:0] s1_elapsed;

  // stage 2: quotient by 1000
  logic        s2_valid;
  logic [1:0]  s2_action;
  logic [3:0]  s2_bstate;
  logic [9:0]  s2_lo;
  logic [8:0]  s2_sat;
  logic [9:0]  s2_quot;

  // stage 3: remainders
  logic        s3_valid;
  logic [1:0]  s3_action;
  logic [3:0]  s3_bstate;
  logic [8:0]  s3_sat;
  logic [9:0]  s3_rem_slow;
  logic [7:0]  s3_rem_fast;

  // pattern state
  bflp_pkg::pat_t pattern_reg;
  bflp_pkg::pat_t pattern_next;
  logic [9:0]     phase_count;
  logic [9:0]     phase_next;
  logic           led_next;

  logic en_out, en3, en2, en1;

  logic [63:0] prod;
  logic [19:0] quot_x1000;
  logic [9:0]  rem_slow;
  logic [7:0]  rem_fast;

  assign en_out   = !led_valid || !led_stall;
  assign en3      = !s3_valid || en_out;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign ev_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= ev_valid;
    end
    if (en1) begin
      s1_action  <= ev_word.action;
      s1_bstate  <= ev_word.button_state;
      s1_elapsed <= ev_word.delta_ms;
    end
  end

  assign prod = {32'd0, s1_elapsed} * {32'd0, bflp_pkg::RECIP_1000};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
    if (en2) begin
      s2_action <= s1_action;
      s2_bstate <= s1_bstate;
      s2_lo     <= s1_elapsed[9:0];
      s2_sat    <= (|s1_elapsed[31:9]) ? bflp_pkg::ELAPSED_SAT : s1_elapsed[8:0];
      s2_quot   <= prod[bflp_pkg::RECIP_SHIFT +: 10];
    end
  end

  // remainder fits in ten bits, so only the low bits of quotient * 1000 matter
  assign quot_x1000 = 20'(s2_quot) * 20'(bflp_pkg::SLOW_PERIOD);
  assign rem_slow   = s2_lo - quot_x1000[9:0];

  always_comb begin
    priority if (rem_slow >= 10'd800) begin
      rem_fast = 8'(rem_slow - 10'd800);
    end else if (rem_slow >= 10'd600) begin
      rem_fast = 8'(rem_slow - 10'd600);
    end else if (rem_slow >= 10'd400) begin
      rem_fast = 8'(rem_slow - 10'd400);
    end else if (rem_slow >= 10'd200) begin
      rem_fast = 8'(rem_slow - 10'd200);
    end else begin
      rem_fast = rem_slow[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
    if (en3) begin
      s3_action   <= s2_action;
      s3_bstate   <= s2_bstate;
      s3_sat      <= s2_sat;
      s3_rem_slow <= rem_slow;
      s3_rem_fast <= rem_fast;
    end
  end

  always_comb begin
    bflp_pkg::pat_t chosen;
    logic           click;
    logic [9:0]     dur;
    logic [9:0]     room;
    logic [10:0]    slow_sum;
    logic [8:0]     fast_sum;

    click = (s3_action == bflp_pkg::ACT_SINGLE) || (s3_action == bflp_pkg::ACT_DOUBLE);

    if (s3_action == bflp_pkg::ACT_SINGLE) begin
      chosen = bflp_pkg::PAT_SINGLE;
    end else if (s3_action == bflp_pkg::ACT_DOUBLE) begin
      chosen = bflp_pkg::PAT_DOUBLE;
    end else begin
      unique case (s3_bstate)
        bflp_pkg::BS_IDLE: begin
          chosen = (pattern_reg == bflp_pkg::PAT_SINGLE ||
                    pattern_reg == bflp_pkg::PAT_DOUBLE) ? pattern_reg : bflp_pkg::PAT_OFF;
        end
        bflp_pkg::BS_PRESSED, bflp_pkg::BS_WAIT_SECOND,
        bflp_pkg::BS_SECOND_PRESSED: begin
          chosen = bflp_pkg::PAT_OFF;
        end
        bflp_pkg::BS_LONG3S: begin
          chosen = bflp_pkg::PAT_SLOW;
        end
        bflp_pkg::BS_LONG10S: begin
          chosen = bflp_pkg::PAT_FAST;
        end
        default: begin
          chosen = pattern_reg;
        end
      endcase
    end

    dur      = (chosen == bflp_pkg::PAT_SINGLE) ? bflp_pkg::FLASH_MS : bflp_pkg::DOUBLE_MS;
    room     = dur - phase_count;
    slow_sum = {1'b0, phase_count} + {1'b0, s3_rem_slow};
    fast_sum = {1'b0, phase_count[7:0]} + {1'b0, s3_rem_fast};

    pattern_next = chosen;
    phase_next   = 10'd0;
    if (!(chosen != pattern_reg || click)) begin
      unique case (chosen)
        bflp_pkg::PAT_SINGLE, bflp_pkg::PAT_DOUBLE: begin
          if ({1'b0, s3_sat} >= room) begin
            pattern_next = bflp_pkg::PAT_OFF;
          end else begin
            phase_next = phase_count + {1'b0, s3_sat};
          end
        end
        bflp_pkg::PAT_SLOW: begin
          phase_next = (slow_sum >= {1'b0, bflp_pkg::SLOW_PERIOD}) ?
                       10'(slow_sum - {1'b0, bflp_pkg::SLOW_PERIOD}) : slow_sum[9:0];
        end
        bflp_pkg::PAT_FAST: begin
          phase_next = (fast_sum >= {1'b0, bflp_pkg::FAST_PERIOD}) ?
                       10'(fast_sum - {1'b0, bflp_pkg::FAST_PERIOD}) : {2'd0, fast_sum[7:0]};
        end
        default: begin
          phase_next = 10'd0;
        end
      endcase
    end

    unique case (pattern_next)
      bflp_pkg::PAT_SINGLE: led_next = 1'b1;
      bflp_pkg::PAT_DOUBLE: led_next = (phase_next < bflp_pkg::FLASH_MS) ||
                                       (phase_next >= bflp_pkg::DOUBLE_GAP_MS);
      bflp_pkg::PAT_SLOW:   led_next = phase_next < bflp_pkg::SLOW_HALF_MS;
      bflp_pkg::PAT_FAST:   led_next = phase_next < {2'd0, bflp_pkg::FAST_HALF_MS};
      default:              led_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid   <= 1'b0;
      pattern_reg <= bflp_pkg::PAT_OFF;
      phase_count <= 10'd0;
    end else if (en_out) begin
      led_valid <= s3_valid;
      if (s3_valid) begin
        pattern_reg <= pattern_next;
        phase_count <= phase_next;
      end
    end
    if (en_out && s3_valid) begin
      led_word.led_on      <= led_next;
      led_word.pattern_now <= pattern_next;
    end
  end

`include "button_feedback_led_pattern_assert.svh"

  `BFLP_IMPLY(a_flash_phase, pattern_reg == bflp_pkg::PAT_SINGLE, phase_count < bflp_pkg::FLASH_MS, "single flash phase past its duration")
  `BFLP_IMPLY(a_double_phase, pattern_reg == bflp_pkg::PAT_DOUBLE, phase_count < bflp_pkg::DOUBLE_MS, "double flash phase past its duration")
  `BFLP_IMPLY(a_off_phase, pattern_reg == bflp_pkg::PAT_OFF, phase_count == 10'd0, "phase not cleared while off")
  `BFLP_IMPLY(a_rem_range, s3_valid, s3_rem_slow < bflp_pkg::SLOW_PERIOD && s3_rem_fast < bflp_pkg::FAST_PERIOD, "remainder out of range")
  `BFLP_CHECK(a_word_state, !led_valid || led_word.pattern_now == pattern_reg, "result word disagrees with pattern state")

endmodule
